// File: hw/rtl/gla_pkg.sv
// Shared widths, constants and types of the gate layer assigner.
package gla_pkg;

  localparam int COUNT_W = 2;
  localparam int QUBIT_W = 6;
  localparam int SLICE_W = 12;
  localparam int TOTAL_W = 13;
  localparam int FILL_W  = 12;

  localparam logic [FILL_W-1:0] FILL_MAX = 12'hFFF;

  typedef struct packed {
    logic placed;
    logic fresh;
  } gla_fill_req_t;

endpackage

// File: hw/rtl/gla_bank.sv
// Qubit slice bank: one write port and two registered read ports.
module gla_bank #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [DW-1:0] rd_data0,
  output logic [DW-1:0] rd_data1,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/gla_lane.sv
// Lane: looks up the last slice of one target qubit and proposes a slice.
module gla_lane #(
  parameter int QUBIT_COUNT = 64,
  parameter int AW          = 6,
  parameter int SW          = 12,
  parameter int NW          = 13
) (
  input  logic                        active,
  input  logic [gla_pkg::QUBIT_W-1:0] qubit,
  input  logic [QUBIT_COUNT-1:0]      seen,
  input  logic [QUBIT_COUNT-1:0]      newer_b,
  input  logic [SW-1:0]               bank_a,
  input  logic [SW-1:0]               bank_b,
  input  logic [1:0]                  wr_mask,
  input  logic [AW-1:0]               wr_idx0,
  input  logic [AW-1:0]               wr_idx1,
  input  logic [SW-1:0]               wr_slice,
  output logic                        target,
  output logic [AW-1:0]               idx,
  output logic [NW-1:0]               candidate
);
  import gla_pkg::*;

  logic          fwd_hit;
  logic [SW-1:0] stored;

  always_comb begin
    target    = active && (32'(qubit) < QUBIT_COUNT);
    idx       = AW'(qubit);
    fwd_hit   = (wr_mask[0] && (wr_idx0 == idx)) || (wr_mask[1] && (wr_idx1 == idx));
    stored    = fwd_hit ? wr_slice : (newer_b[idx] ? bank_b : bank_a);
    candidate = (target && seen[idx]) ? (NW'(stored) + NW'(1)) : '0;
  end

endmodule

// File: hw/rtl/gla_fill.sv
// Slice fill counts: registered lookup, forwarding and saturating update.
module gla_fill #(
  parameter int MAX_SLICES = 4096,
  parameter int SW         = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [SW-1:0]                rd_addr,
  input  gla_pkg::gla_fill_req_t       req,
  input  logic                         wr_go,
  output logic [gla_pkg::FILL_W-1:0]   pos
);
  import gla_pkg::*;

  logic [FILL_W-1:0] mem [MAX_SLICES];
  logic [FILL_W-1:0] mem_q;
  logic [SW-1:0]     addr;
  gla_fill_req_t     cur;
  logic              fwd_valid;
  logic [SW-1:0]     fwd_addr;
  logic [FILL_W-1:0] fwd_val;
  logic [FILL_W-1:0] pos_next;

  always_comb begin
    if (!cur.placed || cur.fresh) begin
      pos = '0;
    end else if (fwd_valid && (fwd_addr == addr)) begin
      pos = fwd_val;
    end else begin
      pos = mem_q;
    end
    pos_next = (pos < FILL_MAX) ? (pos + FILL_W'(1)) : pos;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mem_q <= mem[rd_addr];
      addr  <= rd_addr;
      cur   <= req;
    end
    if (wr_go && cur.placed) begin
      mem[addr] <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (load) begin
      fwd_valid <= wr_go && cur.placed;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fwd_addr <= addr;
      fwd_val  <= pos_next;
    end
  end

endmodule

// File: hw/rtl/gate_layer_assigner_unit.sv
// Top level of the gate layer assigner: lanes, merge, slice state and output register.
//
//  channel dir handshake                 payload
//  gate    in  gate_valid/gate_stall     target_count first_qubit second_qubit last_gate
//  result  out result_valid/result_stall placed slice_index position_in_slice slice_total overflow
//  config  in  cfg_wr_en                 cfg_wr_data (pair_only)
//
// One gate is accepted per cycle while gate_stall is low; its result passes through s2 into the output register.
// The rate is set by the two qubit slice banks, each with a single write port, with forwarding
// of the previous gate's writes into the lanes and into the fill count lookup.
// Reset clears the seen bits and the open slice count directly; no clearing pass is run.
// A stall on the result side holds only the stages that are full, so bubbles are squeezed out.
module gate_layer_assigner_unit #(
  parameter int QUBIT_COUNT = 64,
  parameter int MAX_SLICES  = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        gate_valid,
  output logic                        gate_stall,
  input  logic [gla_pkg::COUNT_W-1:0] target_count,
  input  logic [gla_pkg::QUBIT_W-1:0] first_qubit,
  input  logic [gla_pkg::QUBIT_W-1:0] second_qubit,
  input  logic                        last_gate,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        placed,
  output logic [gla_pkg::SLICE_W-1:0] slice_index,
  output logic [gla_pkg::FILL_W-1:0]  position_in_slice,
  output logic [gla_pkg::TOTAL_W-1:0] slice_total,
  output logic                        overflow
);
  import gla_pkg::*;

  localparam int QAW = (QUBIT_COUNT > 1) ? $clog2(QUBIT_COUNT) : 1;
  localparam int SW  = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int NW  = $clog2(MAX_SLICES + 1);

  logic                   pair_only;

  logic                   en_out;
  logic                   en_s2;
  logic                   en_s1;
  logic                   s1_go;

  logic                   s1_valid;
  logic [COUNT_W-1:0]     s1_count;
  logic [QUBIT_W-1:0]     s1_q0;
  logic [QUBIT_W-1:0]     s1_q1;
  logic                   s1_last;

  logic [QUBIT_COUNT-1:0] seen;
  logic [QUBIT_COUNT-1:0] newer_b;
  logic [NW-1:0]          hw_open;
  logic [NW-1:0]          hw_open_next;

  logic [1:0]             fwd_mask;
  logic [QAW-1:0]         fwd_idx0;
  logic [QAW-1:0]         fwd_idx1;
  logic [SW-1:0]          fwd_slice;

  logic [SW-1:0]          a_rd0;
  logic [SW-1:0]          a_rd1;
  logic [SW-1:0]          b_rd0;
  logic [SW-1:0]          b_rd1;

  logic                   tgt0;
  logic                   tgt1;
  logic [QAW-1:0]         idx0;
  logic [QAW-1:0]         idx1;
  logic [NW-1:0]          cand0;
  logic [NW-1:0]          cand1;

  logic [NW-1:0]          need;
  logic                   skip;
  logic                   ovf;
  logic                   place;
  logic                   fresh;
  logic [NW-1:0]          total;
  gla_fill_req_t          fill_req;

  logic                   s2_valid;
  logic                   s2_placed;
  logic [SW-1:0]          s2_slice;
  logic [NW-1:0]          s2_total;
  logic                   s2_ovf;
  logic [FILL_W-1:0]      s2_pos;

  assign en_out     = !result_valid || !result_stall;
  assign en_s2      = !s2_valid || en_out;
  assign en_s1      = !s1_valid || en_s2;
  assign gate_stall = !en_s1;
  assign s1_go      = s1_valid && en_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_only <= 1'b0;
    end else if (cfg_wr_en) begin
      pair_only <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en_s1) begin
      s1_valid <= gate_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_count <= target_count;
      s1_q0    <= first_qubit;
      s1_q1    <= second_qubit;
      s1_last  <= last_gate;
    end
  end

  gla_bank #(.DEPTH(QUBIT_COUNT), .AW(QAW), .DW(SW)) u_bank_a (
    .clk      (clk),
    .rd_en    (en_s1),
    .rd_addr0 (QAW'(first_qubit)),
    .rd_addr1 (QAW'(second_qubit)),
    .rd_data0 (a_rd0),
    .rd_data1 (a_rd1),
    .wr_en    (s1_go && place && tgt0),
    .wr_addr  (idx0),
    .wr_data  (SW'(need))
  );

  gla_bank #(.DEPTH(QUBIT_COUNT), .AW(QAW), .DW(SW)) u_bank_b (
    .clk      (clk),
    .rd_en    (en_s1),
    .rd_addr0 (QAW'(first_qubit)),
    .rd_addr1 (QAW'(second_qubit)),
    .rd_data0 (b_rd0),
    .rd_data1 (b_rd1),
    .wr_en    (s1_go && place && tgt1),
    .wr_addr  (idx1),
    .wr_data  (SW'(need))
  );

  gla_lane #(.QUBIT_COUNT(QUBIT_COUNT), .AW(QAW), .SW(SW), .NW(NW)) u_lane0 (
    .active    (s1_count != '0),
    .qubit     (s1_q0),
    .seen      (seen),
    .newer_b   (newer_b),
    .bank_a    (a_rd0),
    .bank_b    (b_rd0),
    .wr_mask   (fwd_mask),
    .wr_idx0   (fwd_idx0),
    .wr_idx1   (fwd_idx1),
    .wr_slice  (fwd_slice),
    .target    (tgt0),
    .idx       (idx0),
    .candidate (cand0)
  );

  gla_lane #(.QUBIT_COUNT(QUBIT_COUNT), .AW(QAW), .SW(SW), .NW(NW)) u_lane1 (
    .active    (s1_count[1]),
    .qubit     (s1_q1),
    .seen      (seen),
    .newer_b   (newer_b),
    .bank_a    (a_rd1),
    .bank_b    (b_rd1),
    .wr_mask   (fwd_mask),
    .wr_idx0   (fwd_idx0),
    .wr_idx1   (fwd_idx1),
    .wr_slice  (fwd_slice),
    .target    (tgt1),
    .idx       (idx1),
    .candidate (cand1)
  );

  always_comb begin
    need  = (cand1 > cand0) ? cand1 : cand0;
    skip  = pair_only && !s1_count[1];
    ovf   = !skip && (need == NW'(MAX_SLICES));
    place = !skip && !ovf;
    fresh = need >= hw_open;
    hw_open_next = (place && fresh) ? (need + NW'(1)) : hw_open;
    total = (hw_open_next == '0) ? NW'(1) : hw_open_next;
    fill_req.placed = s1_valid && place;
    fill_req.fresh  = fresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      hw_open <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        seen    <= '0;
        hw_open <= '0;
      end else if (place) begin
        if (tgt0) begin
          seen[idx0] <= 1'b1;
        end
        if (tgt1 && !(tgt0 && (idx0 == idx1))) begin
          seen[idx1] <= 1'b1;
        end
        hw_open <= hw_open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && place) begin
      if (tgt0 && !(tgt1 && (idx1 == idx0))) begin
        newer_b[idx0] <= 1'b0;
      end
      if (tgt1) begin
        newer_b[idx1] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_mask <= '0;
    end else if (en_s1) begin
      fwd_mask <= (s1_go && place) ? {tgt1, tgt0} : 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      fwd_idx0  <= idx0;
      fwd_idx1  <= idx1;
      fwd_slice <= SW'(need);
    end
  end

  gla_fill #(.MAX_SLICES(MAX_SLICES), .SW(SW)) u_fill (
    .clk     (clk),
    .rst     (rst),
    .load    (en_s2),
    .rd_addr (SW'(need)),
    .req     (fill_req),
    .wr_go   (s2_valid && en_out),
    .pos     (s2_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en_s2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_placed <= place;
      s2_slice  <= place ? SW'(need) : '0;
      s2_total  <= total;
      s2_ovf    <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en_out) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      placed            <= s2_placed;
      slice_index       <= SLICE_W'(s2_slice);
      position_in_slice <= s2_pos;
      slice_total       <= TOTAL_W'(s2_total);
      overflow          <= s2_ovf;
    end
  end

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (hw_open == '0) && (seen == '0))
    else $error("schedule not cleared after last gate");

  a_place_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(placed && overflow))
    else $error("gate both placed and overflowed");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !placed) |-> (slice_index == '0) && (position_in_slice == '0))
    else $error("unplaced gate carries a slice or position");

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    hw_open <= NW'(MAX_SLICES))
    else $error("open slice count beyond storage");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (slice_total != '0))
    else $error("slice total of zero reported");
`endif

endmodule
